// File: src/pl2d_pkg.sv
`default_nettype none
package pl2d_pkg;

  localparam int DEF_MAX_POINTS  = 256;
  localparam int DEF_ITER_FACTOR = 100;

  // Q2.14 one, as a shift
  localparam int BIAS_SHIFT = 14;

  localparam logic [15:0] LFSR_MASK = 16'hB400;

  localparam logic [1:0] KIND_LOAD    = 2'd0;
  localparam logic [1:0] KIND_LEARN   = 2'd1;
  localparam logic [1:0] KIND_PREDICT = 2'd2;

  // sign codes, two's complement
  localparam logic [1:0] SGN_ZERO = 2'b00;
  localparam logic [1:0] SGN_POS  = 2'b01;
  localparam logic [1:0] SGN_NEG  = 2'b11;

  typedef struct packed {
    logic        lab_neg;
    logic [15:0] x;
    logic [15:0] y;
  } pt_t;

endpackage
`default_nettype wire

// File: src/perceptron_learning_2d_top.sv
`default_nettype none
// Perceptron learning on up to MAX_POINTS labelled 2D points (Q2.14).
// Command channel: a word is taken at a clock edge with start high and busy
// low. kind 0 loads a point (first_point restarts the set), one per cycle,
// busy never rises and no result follows. kind 1 learns from the current
// weights; kind 2 predicts the sign for coord_x/coord_y; kind 3 is dropped.
// Result words: done is high for exactly one cycle with the weights,
// iterations, converged and predicted; the receiver cannot stall, so the
// result is simply presented once. Predict: the sign comes from the dot-product pipe.
// Learn: each pass scans the point memory one entry a cycle through the
// two-stage dot-product pipe, listing misclassified points; each weight
// update then waits on the remainder unit, which picks a listed point, and
// then reads the list and the point memory.
// seed_we/seed_data set the LFSR seed (0 is held as 1); write while idle.
// Reset: point count and weights zero, LFSR 1; the point and list memories
// hold garbage until written, only written entries are ever read.
module perceptron_learning_2d_top #(
  parameter int MAX_POINTS  = pl2d_pkg::DEF_MAX_POINTS,
  parameter int ITER_FACTOR = pl2d_pkg::DEF_ITER_FACTOR
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         kind,
  input  wire logic               first_point,
  input  wire logic signed [15:0] coord_x,
  input  wire logic signed [15:0] coord_y,
  input  wire logic signed [1:0]  label,
  input  wire logic               seed_we,
  input  wire logic [15:0]        seed_data,
  output logic                    done,
  output logic signed [31:0]      bias_weight,
  output logic signed [31:0]      weight_x,
  output logic signed [31:0]      weight_y,
  output logic [14:0]             iterations,
  output logic                    converged,
  output logic signed [1:0]       predicted
);
  import pl2d_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS * ITER_FACTOR + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MODW = 3'd2;
  localparam logic [2:0] S_LRD  = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_PRED = 3'd5;

  function automatic logic [15:0] lfsr_step(input logic [15:0] v);
    logic [15:0] n;
    n = {1'b0, v[15:1]} ^ (v[0] ? LFSR_MASK : 16'h0000);
    if (n == 16'h0000) begin
      n = 16'h0001;
    end
    return n;
  endfunction

  // add d to w, clip at the 32-bit limits
  function automatic logic [31:0] sat_add(input logic [31:0] w, input logic [16:0] d);
    logic [32:0] s;
    s = {w[31], w} + {{16{d[16]}}, d};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic [15:0]   lfsr;
  logic [IW-1:0] iters;
  logic [IW-1:0] cap;
  logic [CW-1:0] issue;
  logic [CW-1:0] rcnt;
  logic [CW-1:0] nwrong;

  // memories: point store and misclassified index list
  pt_t           pmem [MAX_POINTS];
  logic [AW-1:0] lmem [MAX_POINTS];
  pt_t           pt_q;
  logic [AW-1:0] lq;
  logic [AW-1:0] paddr;

  logic              rv;
  logic [AW-1:0]     ridx;
  logic              pv;
  logic signed [15:0] px;
  logic signed [15:0] py;

  logic              accept;
  logic [CW-1:0]     ld_idx;

  logic              dot_v;
  logic [AW:0]       dot_tag;
  logic [1:0]        dot_sgn;
  logic              wrong;
  logic signed [15:0] dot_x;
  logic signed [15:0] dot_y;
  logic [AW:0]       dot_in_tag;

  logic              mod_go;
  logic [15:0]       mod_arg;
  logic              mod_rdy;
  logic [CW-1:0]     mod_rem;

  logic [IW-1:0]     iters_next;
  logic [16:0]       dx;
  logic [16:0]       dy;
  logic [16:0]       db;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign ld_idx = first_point ? '0 : count;

  assign paddr = (state == S_SCAN) ? issue[AW-1:0] : lq;

  assign dot_x      = (state == S_PRED) ? px : $signed(pt_q.x);
  assign dot_y      = (state == S_PRED) ? py : $signed(pt_q.y);
  assign dot_in_tag = {pt_q.lab_neg, ridx};

  // zero sum counts as wrong for either label
  assign wrong = dot_tag[AW] ? (dot_sgn != SGN_NEG) : (dot_sgn != SGN_POS);

  assign iters_next = iters + IW'(1);
  assign dx = pt_q.lab_neg ? -{pt_q.x[15], pt_q.x} : {pt_q.x[15], pt_q.x};
  assign dy = pt_q.lab_neg ? -{pt_q.y[15], pt_q.y} : {pt_q.y[15], pt_q.y};
  assign db = pt_q.lab_neg ? -(17'd1 << BIAS_SHIFT) : (17'd1 << BIAS_SHIFT);

  pl2d_dot #(
    .TW(AW + 1)
  ) u_dot (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rv | pv),
    .in_tag   (dot_in_tag),
    .x        (dot_x),
    .y        (dot_y),
    .w0       (bias_weight),
    .w1       (weight_x),
    .w2       (weight_y),
    .out_valid(dot_v),
    .out_tag  (dot_tag),
    .out_sign (dot_sgn)
  );

  pl2d_mod #(
    .DW(CW)
  ) u_mod (
    .clk     (clk),
    .rst     (rst),
    .go      (mod_go),
    .dividend(mod_arg),
    .divisor (nwrong),
    .rdy     (mod_rdy),
    .rem     (mod_rem)
  );

  // memory ports, registered reads
  always_ff @(posedge clk) begin
    if (accept && (kind == KIND_LOAD) && (ld_idx < CW'(MAX_POINTS))) begin
      pmem[ld_idx[AW-1:0]] <= '{lab_neg: label[1], x: coord_x, y: coord_y};
    end
    pt_q <= pmem[paddr];
    if ((state == S_SCAN) && dot_v && wrong) begin
      lmem[nwrong[AW-1:0]] <= dot_tag[AW-1:0];
    end
    lq <= lmem[mod_rem[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      lfsr        <= 16'h0001;
      bias_weight <= '0;
      weight_x    <= '0;
      weight_y    <= '0;
      done        <= 1'b0;
      rv          <= 1'b0;
      pv          <= 1'b0;
      mod_go      <= 1'b0;
      iters       <= '0;
      cap         <= '0;
      issue       <= '0;
      rcnt        <= '0;
      nwrong      <= '0;
    end else begin
      done   <= 1'b0;
      pv     <= 1'b0;
      rv     <= 1'b0;
      mod_go <= 1'b0;
      if (seed_we) begin
        lfsr <= (seed_data == 16'h0000) ? 16'h0001 : seed_data;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_LOAD: begin
                if (ld_idx < CW'(MAX_POINTS)) begin
                  count <= ld_idx + CW'(1);
                end else begin
                  count <= ld_idx;
                end
              end
              KIND_LEARN: begin
                iters  <= '0;
                cap    <= IW'(count * ITER_FACTOR);
                issue  <= '0;
                rcnt   <= '0;
                nwrong <= '0;
                if (count == '0) begin
                  done       <= 1'b1;
                  iterations <= '0;
                  converged  <= 1'b1;
                  predicted  <= SGN_ZERO;
                end else begin
                  state <= S_SCAN;
                end
              end
              KIND_PREDICT: begin
                px    <= coord_x;
                py    <= coord_y;
                pv    <= 1'b1;
                state <= S_PRED;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          if (issue < count) begin
            rv    <= 1'b1;
            ridx  <= issue[AW-1:0];
            issue <= issue + CW'(1);
          end
          if (dot_v) begin
            rcnt <= rcnt + CW'(1);
            if (wrong) begin
              nwrong <= nwrong + CW'(1);
            end
          end
          if (rcnt == count) begin
            if (nwrong == '0) begin
              done       <= 1'b1;
              iterations <= 15'(iters);
              converged  <= 1'b1;
              predicted  <= SGN_ZERO;
              state      <= S_IDLE;
            end else begin
              lfsr    <= lfsr_step(lfsr);
              mod_arg <= lfsr_step(lfsr);
              mod_go  <= 1'b1;
              state   <= S_MODW;
            end
          end
        end
        S_MODW: begin
          // list entry at the remainder is latched on this edge
          if (mod_rdy) begin
            state <= S_LRD;
          end
        end
        S_LRD: begin
          state <= S_UPD;
        end
        S_UPD: begin
          bias_weight <= sat_add(bias_weight, db);
          weight_x    <= sat_add(weight_x, dx);
          weight_y    <= sat_add(weight_y, dy);
          iters       <= iters_next;
          if (iters_next >= cap) begin
            done       <= 1'b1;
            iterations <= 15'(iters_next);
            converged  <= 1'b0;
            predicted  <= SGN_ZERO;
            state      <= S_IDLE;
          end else begin
            issue  <= '0;
            rcnt   <= '0;
            nwrong <= '0;
            state  <= S_SCAN;
          end
        end
        S_PRED: begin
          if (dot_v) begin
            done       <= 1'b1;
            iterations <= '0;
            converged  <= 1'b0;
            predicted  <= dot_sgn;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a result word is only presented with the control back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("result strobe outside idle");

  // list fill never runs ahead of scanned results
  a_wrong_le_seen: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (nwrong <= rcnt) && (rcnt <= issue))
    else $error("scan counters out of order");

  // a pick is only made from a nonempty list
  a_pick_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_MODW) |-> (nwrong != '0))
    else $error("pick with empty misclassified list");

  // update never runs past the cap
  a_under_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (iters < cap))
    else $error("update beyond iteration cap");

endmodule
`default_nettype wire

// File: src/pl2d_mod.sv
`default_nettype none
module pl2d_mod #(
  parameter int DW = 9
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire logic [15:0]   dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               rdy,
  output logic [DW-1:0]      rem
);
  import pl2d_pkg::*;

  // restoring remainder, one dividend bit per cycle
  logic [15:0]   q;
  logic [DW-1:0] d;
  logic [4:0]    cnt;
  logic          run;
  logic [DW:0]   t;
  logic [DW:0]   t_sub;

  assign t     = {rem, q[15]};
  assign t_sub = t - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rdy <= 1'b0;
      cnt <= '0;
    end else begin
      rdy <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
        q   <= dividend;
        d   <= divisor;
        rem <= '0;
      end else if (run) begin
        q <= {q[14:0], 1'b0};
        if (t >= {1'b0, d}) begin
          rem <= t_sub[DW-1:0];
        end else begin
          rem <= t[DW-1:0];
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd15) begin
          run <= 1'b0;
          rdy <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: src/pl2d_dot.sv
`default_nettype none
module pl2d_dot #(
  parameter int TW = 9
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic [TW-1:0]      in_tag,
  input  wire logic signed [15:0] x,
  input  wire logic signed [15:0] y,
  input  wire logic signed [31:0] w0,
  input  wire logic signed [31:0] w1,
  input  wire logic signed [31:0] w2,
  output logic                    out_valid,
  output logic [TW-1:0]           out_tag,
  output logic [1:0]              out_sign
);
  import pl2d_pkg::*;

  logic               v1;
  logic [TW-1:0]      tag1;
  logic signed [47:0] p1;
  logic signed [47:0] p2;
  logic signed [47:0] pb;
  logic signed [49:0] s;

  assign s = 50'(p1) + 50'(p2) + 50'(pb);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      out_valid <= v1;
    end
    tag1    <= in_tag;
    p1      <= w1 * x;
    p2      <= w2 * y;
    pb      <= 48'(w0) <<< BIAS_SHIFT;
    out_tag <= tag1;
    if (s == '0) begin
      out_sign <= SGN_ZERO;
    end else if (s[49]) begin
      out_sign <= SGN_NEG;
    end else begin
      out_sign <= SGN_POS;
    end
  end
endmodule
`default_nettype wire
